// ===== rtl/mtd_pkg.sv =====
// Shared types and constants for the modifier tap detector.
// No dependencies; imported by mtd_step, modifier_tap_detector_core and the testbench.
package mtd_pkg;

    localparam logic [7:0]  VK_SHIFT_ANY   = 8'h10;
    localparam logic [7:0]  VK_SHIFT_LEFT  = 8'hA0;
    localparam logic [7:0]  VK_SHIFT_RIGHT = 8'hA1;

    localparam logic [1:0]  PH_IDLE     = 2'd0;
    localparam logic [1:0]  PH_ARMED    = 2'd1;
    localparam logic [1:0]  PH_POISONED = 2'd2;

    localparam logic [15:0] MAX_HOLD_RESET = 16'd300;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  vk;
        logic        key_up;
        logic        ctrl_held;
        logic        alt_held;
        logic        win_held;
        logic [15:0] hw_scan;
        logic [31:0] time_ms;
    } mtd_event_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [15:0] saved_scan;
        logic [31:0] saved_ms;
    } mtd_state_t;

endpackage

// ===== rtl/mtd_step.sv =====
// Per-event phase update and tap decision, purely combinational.
// Depends on mtd_pkg.
module mtd_step (
    input  mtd_pkg::mtd_event_t ev,
    input  mtd_pkg::mtd_state_t state,
    input  logic [15:0]         max_hold_ms,
    output mtd_pkg::mtd_state_t state_next,
    output logic                toggle
);
    import mtd_pkg::*;

    logic        is_shift;
    logic        mods;
    logic [31:0] held;

    assign is_shift = (ev.vk == VK_SHIFT_ANY) || (ev.vk == VK_SHIFT_LEFT) ||
                      (ev.vk == VK_SHIFT_RIGHT);
    assign mods     = ev.ctrl_held | ev.alt_held | ev.win_held;
    assign held     = ev.time_ms - state.saved_ms;

    always_comb begin
        state_next = state;
        toggle     = 1'b0;
        if (ev.req_type || !is_shift) begin
            if (state.phase == PH_ARMED) begin
                state_next.phase = PH_POISONED;
            end
        end else if (!ev.key_up) begin
            case (state.phase)
                PH_ARMED: begin
                    state_next.phase = PH_POISONED;
                end
                PH_IDLE: begin
                    if (mods) begin
                        state_next.phase = PH_POISONED;
                    end else begin
                        state_next.phase      = PH_ARMED;
                        state_next.saved_scan = ev.hw_scan;
                        state_next.saved_ms   = ev.time_ms;
                    end
                end
                default: begin
                    state_next = state;
                end
            endcase
        end else begin
            toggle = (state.phase == PH_ARMED) && (ev.hw_scan == state.saved_scan) &&
                     !mods && (held <= {16'd0, max_hold_ms});
            state_next.phase      = PH_IDLE;
            state_next.saved_scan = 16'd0;
            state_next.saved_ms   = 32'd0;
        end
    end

endmodule

// ===== rtl/modifier_tap_detector_core.sv =====
// Top level of the modifier tap detector: input register, step logic, result register.
// Depends on mtd_pkg and mtd_step.
//
// Detects a clean solo tap of a Shift key. Every input beat yields exactly one output
// beat carrying toggle. The block takes one beat per cycle while the output is taken:
// the phase update loops through mtd_step and the input stage advances whenever the
// output register is empty or taken. max_hold_ms (reset 300) is written via cfg; the
// user must write it only while no beat is in flight, which the block does not enforce.
module modifier_tap_detector_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] vk, [8] key_up, [9] ctrl_held, [10] alt_held, [11] win_held,
    // [27:12] hw_scan, [59:28] time_ms, [63:60] zero
    input  logic [63:0] s_tdata,
    // [0] req_type
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] toggle, [7:1] zero
    output logic [7:0]  m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import mtd_pkg::*;

    logic        in_valid_reg;
    mtd_event_t  in_reg;
    logic        out_valid_reg;
    logic        toggle_reg;
    logic        toggle_next;
    mtd_state_t  state_reg;
    mtd_state_t  state_next;
    logic [15:0] max_hold_reg;
    logic        advance;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'd0, toggle_reg};

    mtd_step u_step (
        .ev          (in_reg),
        .state       (state_reg),
        .max_hold_ms (max_hold_reg),
        .state_next  (state_next),
        .toggle      (toggle_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            max_hold_reg  <= MAX_HOLD_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_hold_reg <= cfg_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg.req_type  <= s_tuser[0];
            in_reg.vk        <= s_tdata[7:0];
            in_reg.key_up    <= s_tdata[8];
            in_reg.ctrl_held <= s_tdata[9];
            in_reg.alt_held  <= s_tdata[10];
            in_reg.win_held  <= s_tdata[11];
            in_reg.hw_scan   <= s_tdata[27:12];
            in_reg.time_ms   <= s_tdata[59:28];
        end
        if (advance && in_valid_reg) begin
            toggle_reg <= toggle_next;
        end
    end

endmodule

// ===== rtl/mtd_checker.sv =====
// Port-level checks for the modifier tap detector, bound to the top level.
// Depends on modifier_tap_detector_core.
module mtd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    logic last_toggle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_toggle_reg <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            last_toggle_reg <= m_tdata[0];
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output beat present after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:1] == 7'd0)
        else $error("output padding not zero");

    a_no_double_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tdata[0] |-> !last_toggle_reg)
        else $error("toggle on two consecutive beats");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("output beat without matching input beat");

endmodule

bind modifier_tap_detector_core mtd_checker u_mtd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for modifier_tap_detector_core: drives key and
// other-input beats, predicts the toggle result of each and checks it in order.
// Depends on mtd_pkg and the RTL of the block.
module tb_top;
    import mtd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    class toggle_tracker;
        logic [1:0]  phase;
        logic [15:0] saved_scan;
        logic [31:0] saved_ms;
        logic [15:0] hold_limit;
        bit          exp_toggle_q[$];
        int          errors;

        function new();
            phase      = PH_IDLE;
            saved_scan = '0;
            saved_ms   = '0;
            hold_limit = MAX_HOLD_RESET;
            errors     = 0;
        endfunction

        function void set_hold(logic [15:0] value);
            hold_limit = value;
        endfunction

        function int pending();
            return exp_toggle_q.size();
        endfunction

        function void note_event(mtd_event_t ev);
            logic        shift_key;
            logic        mods;
            logic [31:0] held;
            bit          tog;
            shift_key = (ev.vk == VK_SHIFT_ANY) || (ev.vk == VK_SHIFT_LEFT) ||
                        (ev.vk == VK_SHIFT_RIGHT);
            mods = ev.ctrl_held | ev.alt_held | ev.win_held;
            tog  = 1'b0;
            if (ev.req_type || !shift_key) begin
                if (phase == PH_ARMED)
                    phase = PH_POISONED;
            end else if (!ev.key_up) begin
                if (phase == PH_ARMED) begin
                    phase = PH_POISONED;
                end else if (phase == PH_IDLE) begin
                    if (mods) begin
                        phase = PH_POISONED;
                    end else begin
                        phase      = PH_ARMED;
                        saved_scan = ev.hw_scan;
                        saved_ms   = ev.time_ms;
                    end
                end
            end else begin
                held = ev.time_ms - saved_ms;
                tog  = (phase == PH_ARMED) && (ev.hw_scan == saved_scan) && !mods &&
                       (held <= {16'd0, hold_limit});
                phase      = PH_IDLE;
                saved_scan = '0;
                saved_ms   = '0;
            end
            exp_toggle_q.push_back(tog);
        endfunction

        function void check_toggle(logic [7:0] data);
            bit want;
            if (exp_toggle_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual toggle %b",
                         $time, data[0]);
            end else begin
                want = exp_toggle_q.pop_front();
                if (data[0] !== want) begin
                    errors++;
                    $display("%0t: toggle mismatch, expected %b, actual %b",
                             $time, want, data[0]);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    toggle_tracker tracker = new();
    bit            quiet_mode;
    int            items_sent;
    int            stall_left;
    int            idle_cycles;

    modifier_tap_detector_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic mtd_event_t mk_ev(logic req, logic [7:0] vk, logic up, logic c,
                                         logic a, logic w, logic [15:0] sc,
                                         logic [31:0] t);
        mtd_event_t ev;
        ev.req_type  = req;
        ev.vk        = vk;
        ev.key_up    = up;
        ev.ctrl_held = c;
        ev.alt_held  = a;
        ev.win_held  = w;
        ev.hw_scan   = sc;
        ev.time_ms   = t;
        return ev;
    endfunction

    function automatic mtd_event_t rand_ev();
        return mk_ev(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     16'($urandom_range(0, 65535)), $urandom);
    endfunction

    function automatic logic [7:0] rand_shift();
        case ($urandom_range(0, 2))
            0: return VK_SHIFT_ANY;
            1: return VK_SHIFT_LEFT;
            default: return VK_SHIFT_RIGHT;
        endcase
    endfunction

    // Entered and left at a falling edge; valid stays high into the next beat.
    task automatic send_event(mtd_event_t ev);
        if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = ev.req_type;
        s_tdata  = {4'b0, ev.time_ms, ev.hw_scan, ev.win_held, ev.alt_held,
                    ev.ctrl_held, ev.key_up, ev.vk};
        do @(posedge aclk); while (!s_tready);
        tracker.note_event(ev);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic write_hold(logic [15:0] value);
        s_tvalid = 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_hold(value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_taps(int target);
        logic [31:0] t0;
        logic [31:0] delta;
        logic [15:0] sc;
        logic [15:0] hold;
        mtd_event_t  noise;
        while (items_sent < target) begin
            hold = tracker.hold_limit;
            t0   = $urandom;
            sc   = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
            case ($urandom_range(0, 5))
                0: delta = $urandom_range(0, hold);
                1: delta = {16'd0, hold};
                2: delta = {16'd0, hold} + 32'd1;
                3: delta = $urandom;
                4: delta = '0;
                default: delta = -32'($urandom_range(1, 1000));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: begin
                    if ($urandom_range(0, 5) == 0)
                        send_event(mk_ev(0, rand_shift(), 0, 1'($urandom_range(0, 1)),
                                         1'($urandom_range(0, 1)),
                                         1'($urandom_range(0, 1)), sc, t0));
                    else
                        send_event(mk_ev(0, rand_shift(), 0, 0, 0, 0, sc, t0));
                    if ($urandom_range(0, 4) == 0) begin
                        noise = rand_ev();
                        case ($urandom_range(0, 2))
                            0: noise.req_type = 1'b1;
                            1: noise.req_type = 1'b0;
                            default: begin
                                noise.req_type = 1'b0;
                                noise.vk       = rand_shift();
                                noise.key_up   = 1'b0;
                            end
                        endcase
                        send_event(noise);
                    end
                    send_event(mk_ev(0, rand_shift(), 1,
                                     $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                                     $urandom_range(0, 7) == 0,
                                     ($urandom_range(0, 7) == 0) ? 16'($urandom) : sc,
                                     t0 + delta));
                end
                7, 8: send_event(rand_ev());
                default: begin
                    noise        = rand_ev();
                    noise.vk     = rand_shift();
                    send_event(noise);
                end
            endcase
        end
    endtask

    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (quiet_mode) begin
                m_tready = 1'b1;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 7) == 0) begin
                m_tready   = 1'b0;
                stall_left = $urandom_range(1, 13) - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_toggle(m_tdata);
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        quiet_mode = 1'b0;
        items_sent = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_event(mk_ev(0, VK_SHIFT_LEFT,  0, 0, 0, 0, 16'h002A, 32'd1000));
        send_event(mk_ev(0, VK_SHIFT_LEFT,  1, 0, 0, 0, 16'h002A, 32'd1300));
        send_event(mk_ev(0, VK_SHIFT_RIGHT, 0, 0, 0, 0, 16'h0036, 32'd0));
        send_event(mk_ev(0, VK_SHIFT_RIGHT, 1, 0, 0, 0, 16'h0036, 32'd301));
        send_event(mk_ev(0, VK_SHIFT_ANY,   0, 0, 0, 0, 16'hFFFF, 32'hFFFF_FF00));
        send_event(mk_ev(0, VK_SHIFT_ANY,   1, 0, 0, 0, 16'hFFFF, 32'h0000_002B));
        send_event(mk_ev(0, VK_SHIFT_LEFT,  0, 0, 0, 0, 16'h0000, 32'd500));
        send_event(mk_ev(0, VK_SHIFT_LEFT,  1, 0, 0, 0, 16'h0000, 32'd499));
        send_event(mk_ev(0, VK_SHIFT_LEFT,  0, 1, 0, 0, 16'h002A, 32'd10));
        send_event(mk_ev(0, VK_SHIFT_RIGHT, 0, 0, 0, 0, 16'h002A, 32'd11));
        send_event(mk_ev(0, VK_SHIFT_RIGHT, 1, 0, 0, 0, 16'h002A, 32'd12));
        send_event(mk_ev(0, VK_SHIFT_LEFT,  0, 0, 1, 0, 16'h002A, 32'd20));
        send_event(mk_ev(0, VK_SHIFT_LEFT,  1, 0, 0, 0, 16'h002A, 32'd21));
        send_event(mk_ev(0, VK_SHIFT_LEFT,  0, 0, 0, 1, 16'h002A, 32'd30));
        send_event(mk_ev(0, VK_SHIFT_LEFT,  1, 0, 0, 0, 16'h002A, 32'd31));
        send_event(mk_ev(0, VK_SHIFT_LEFT,  0, 0, 0, 0, 16'h0001, 32'd100));
        send_event(mk_ev(0, 8'h00,          0, 0, 0, 0, 16'h0001, 32'd101));
        send_event(mk_ev(0, VK_SHIFT_LEFT,  1, 0, 0, 0, 16'h0001, 32'd102));
        send_event(mk_ev(0, VK_SHIFT_RIGHT, 0, 0, 0, 0, 16'h0002, 32'hFFFF_FFFF));
        send_event(mk_ev(1, VK_SHIFT_LEFT,  1, 1, 1, 1, 16'hFFFF, 32'hFFFF_FFFF));
        send_event(mk_ev(0, VK_SHIFT_RIGHT, 1, 0, 0, 0, 16'h0002, 32'd0));
        send_event(mk_ev(0, VK_SHIFT_ANY,   0, 0, 0, 0, 16'h0003, 32'd5));
        send_event(mk_ev(0, VK_SHIFT_ANY,   0, 0, 0, 0, 16'h0003, 32'd6));
        send_event(mk_ev(0, VK_SHIFT_ANY,   1, 0, 0, 0, 16'h0003, 32'd7));
        send_event(mk_ev(0, VK_SHIFT_LEFT,  0, 0, 0, 0, 16'h0004, 32'd8));
        send_event(mk_ev(0, 8'hFF,          1, 0, 0, 0, 16'h0004, 32'd9));
        send_event(mk_ev(0, VK_SHIFT_LEFT,  1, 0, 0, 0, 16'h0004, 32'd10));
        send_event(mk_ev(0, VK_SHIFT_LEFT,  0, 0, 0, 0, 16'h0005, 32'd0));
        send_event(mk_ev(0, VK_SHIFT_LEFT,  1, 0, 0, 0, 16'h0006, 32'd1));
        send_event(mk_ev(0, VK_SHIFT_RIGHT, 0, 0, 0, 0, 16'h0007, 32'd2));
        send_event(mk_ev(0, VK_SHIFT_RIGHT, 1, 1, 0, 0, 16'h0007, 32'd3));
        send_event(mk_ev(0, VK_SHIFT_LEFT,  1, 0, 0, 0, 16'h0000, 32'd4));

        write_hold(16'd0);
        random_taps(510);
        write_hold(16'hFFFF);
        random_taps(990);
        write_hold(16'($urandom_range(1, 2000)));
        random_taps(1470);
        write_hold(MAX_HOLD_RESET);
        quiet_mode = 1'b1;
        random_taps(1950);
        s_tvalid = 1'b0;

        while (tracker.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (tracker.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/mtd_pkg.sv
rtl/mtd_step.sv
rtl/modifier_tap_detector_core.sv
rtl/mtd_checker.sv
test/tb_top.sv
